// ----- rtl/core/ncs_pkg.sv -----
// Package for the named counting semaphore table.
// Holds item kinds, status codes, item and result types and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    localparam int SEM_COUNT_DEF    = 32;
    localparam int WAIT_DEPTH_DEF   = 16;
    localparam int TASK_ID_BITS_DEF = 6;

    localparam int NAME_IN_CHARS = 20;
    localparam int NAME_CHARS    = 19;
    localparam int NAME_BITS     = 8 * NAME_CHARS;
    localparam int COUNT_BITS    = 16;

    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = 16'sh8000;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 16'sh7fff;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_SET    = 2'd1,
        KIND_WAIT   = 2'd2,
        KIND_SIGNAL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_QFULL  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                         kind;
        logic [4:0]                    sem_id;
        logic signed [COUNT_BITS-1:0]  set_value;
        logic [5:0]                    task_id;
        logic [8*NAME_IN_CHARS-1:0]    name;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] result_id;
        logic       caller_blocks;
        logic       woke;
        logic [5:0] woken_task;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ncs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ncs_seq.sv -----
// Sequencer and datapath of the semaphore table: entry memory, waiter memory,
// name scan, count update and ring bookkeeping. Uses ncs_pkg and ncs_ram.
`timescale 1ns / 1ps
`default_nettype none

module ncs_seq import ncs_pkg::*; #(
    parameter int SEM_COUNT    = SEM_COUNT_DEF,
    parameter int WAIT_DEPTH   = WAIT_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int SEM_BITS   = $clog2(SEM_COUNT);
    localparam int HEAD_BITS  = $clog2(WAIT_DEPTH);
    localparam int FILL_BITS  = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_BITS   = HEAD_BITS + 2;
    localparam int RING_DEPTH = SEM_COUNT * WAIT_DEPTH;
    localparam int RING_BITS  = $clog2(RING_DEPTH);

    typedef struct packed {
        logic                          used;
        logic signed [COUNT_BITS-1:0]  count;
        logic [NAME_BITS-1:0]          name;
        logic [HEAD_BITS-1:0]          head;
        logic [FILL_BITS-1:0]          fill;
    } entry_t;

    localparam int ENT_BITS = $bits(entry_t);
    localparam logic [SEM_BITS-1:0] LAST_ID = SEM_BITS'(SEM_COUNT - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_CLAIM = 6'b000100,
        ST_ENT   = 6'b001000,
        ST_RING  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    kind_t                        kind_reg, kind_next;
    logic [SEM_BITS-1:0]          id_reg, id_next;
    logic signed [COUNT_BITS-1:0] val_reg, val_next;
    logic [TASK_ID_BITS-1:0]      task_reg, task_next;
    logic [NAME_BITS-1:0]         name_reg, name_next;
    logic [SEM_BITS-1:0]          chk_reg, chk_next;
    logic                         free_found_reg, free_found_next;
    logic [SEM_BITS-1:0]          free_idx_reg, free_idx_next;
    entry_t                       free_ent_reg, free_ent_next;
    res_t                         res_reg, res_next;
    logic [SEM_COUNT-1:0]         vld_reg;
    logic                         rd_vld_reg;

    logic                         ent_re, ent_we;
    logic [SEM_BITS-1:0]          ent_raddr, ent_waddr;
    logic [ENT_BITS-1:0]          ent_rdata;
    entry_t                       cur, wr_ent;

    logic                         ring_re, ring_we;
    logic [RING_BITS-1:0]         ring_raddr, ring_waddr, ring_base;
    logic [TASK_ID_BITS-1:0]      ring_rdata;

    logic [NAME_CHARS-1:0]        ch_nz, keep;
    logic [NAME_BITS-1:0]         norm_name;
    logic                         in_range, accept, name_hit;

    logic signed [COUNT_BITS-1:0] cnt_dec, cnt_inc;
    logic [SUM_BITS-1:0]          tail_sum;
    logic [HEAD_BITS-1:0]         tail_slot, head_inc;
    logic                         q_full;

    for (genvar k = 0; k < NAME_CHARS; k++) begin : g_norm
        assign ch_nz[k] = |in_item.name[8*k +: 8];
        assign keep[k]  = &ch_nz[k:0];
        assign norm_name[8*k +: 8] = keep[k] ? in_item.name[8*k +: 8] : 8'h00;
    end

    assign in_range = (32'(in_item.sem_id) < 32'(SEM_COUNT));
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    assign cur      = rd_vld_reg ? entry_t'(ent_rdata) : '0;
    assign name_hit = cur.used && (cur.name == name_reg);

    assign cnt_dec   = (cur.count == COUNT_MIN) ? cur.count : cur.count - 16'sd1;
    assign cnt_inc   = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'sd1;
    assign q_full    = (cur.fill >= FILL_BITS'(WAIT_DEPTH));
    assign tail_sum  = SUM_BITS'(cur.head) + SUM_BITS'(cur.fill);
    assign tail_slot = (tail_sum >= SUM_BITS'(WAIT_DEPTH)) ?
                       HEAD_BITS'(tail_sum - SUM_BITS'(WAIT_DEPTH)) : HEAD_BITS'(tail_sum);
    assign head_inc  = (cur.head == HEAD_BITS'(WAIT_DEPTH - 1)) ? '0 : cur.head + 1'b1;

    assign ring_base  = RING_BITS'(id_reg) * RING_BITS'(WAIT_DEPTH);
    assign ring_waddr = ring_base + RING_BITS'(tail_slot);
    assign ring_raddr = ring_base + RING_BITS'(cur.head);

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        val_next        = val_reg;
        task_next       = task_reg;
        name_next       = name_reg;
        chk_next        = chk_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_ent_next   = free_ent_reg;
        res_next        = res_reg;
        ent_re          = 1'b0;
        ent_raddr       = '0;
        ent_we          = 1'b0;
        ent_waddr       = id_reg;
        wr_ent          = cur;
        ring_re         = 1'b0;
        ring_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next       = in_item.kind;
                    id_next         = SEM_BITS'(in_item.sem_id);
                    val_next        = in_item.set_value;
                    task_next       = TASK_ID_BITS'(in_item.task_id);
                    name_next       = norm_name;
                    chk_next        = '0;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    if (in_item.kind == KIND_CREATE) begin
                        ent_re     = 1'b1;
                        state_next = ST_SCAN;
                    end else if (in_range) begin
                        ent_re     = 1'b1;
                        ent_raddr  = SEM_BITS'(in_item.sem_id);
                        state_next = ST_ENT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                ent_re    = 1'b1;
                ent_raddr = (chk_reg == LAST_ID) ? '0 : chk_reg + 1'b1;
                if (name_hit) begin
                    res_next.result_id = 5'(chk_reg);
                    state_next         = ST_DONE;
                end else begin
                    if (!cur.used && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_reg;
                        free_ent_next   = cur;
                    end
                    if (chk_reg == LAST_ID) begin
                        if (free_found_reg || !cur.used) begin
                            state_next = ST_CLAIM;
                        end else begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_DONE;
                        end
                    end else begin
                        chk_next = chk_reg + 1'b1;
                    end
                end
            end
            ST_CLAIM: begin
                wr_ent             = free_ent_reg;
                wr_ent.used        = 1'b1;
                wr_ent.name        = name_reg;
                ent_we             = 1'b1;
                ent_waddr          = free_idx_reg;
                res_next.result_id = 5'(free_idx_reg);
                state_next         = ST_DONE;
            end
            ST_ENT: begin
                state_next = ST_DONE;
                case (kind_reg)
                    KIND_SET: begin
                        wr_ent.count = val_reg;
                        ent_we       = 1'b1;
                    end
                    KIND_WAIT: begin
                        if (cnt_dec < 16'sd0) begin
                            if (q_full) begin
                                res_next.status = STAT_QFULL;
                            end else begin
                                wr_ent.count           = cnt_dec;
                                wr_ent.fill            = cur.fill + 1'b1;
                                ent_we                 = 1'b1;
                                ring_we                = 1'b1;
                                res_next.caller_blocks = 1'b1;
                            end
                        end else begin
                            wr_ent.count = cnt_dec;
                            ent_we       = 1'b1;
                        end
                    end
                    KIND_SIGNAL: begin
                        wr_ent.count = cnt_inc;
                        ent_we       = 1'b1;
                        if (cnt_inc <= 16'sd0 && cur.fill != '0) begin
                            wr_ent.head   = head_inc;
                            wr_ent.fill   = cur.fill - 1'b1;
                            ring_re       = 1'b1;
                            res_next.woke = 1'b1;
                            state_next    = ST_RING;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RING: begin
                res_next.woken_task = 6'(ring_rdata);
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ent_we) begin
                vld_reg[ent_waddr] <= 1'b1;
            end
            if (ent_re) begin
                rd_vld_reg <= vld_reg[ent_raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        val_reg        <= val_next;
        task_reg       <= task_next;
        name_reg       <= name_next;
        chk_reg        <= chk_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        free_ent_reg   <= free_ent_next;
        res_reg        <= res_next;
    end

    ncs_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (SEM_COUNT)
    ) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (wr_ent),
        .rd_en   (ent_re),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    ncs_ram #(
        .WIDTH (TASK_ID_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (task_reg),
        .rd_en   (ring_re),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    a_ent_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ent_we |-> (state_reg == ST_ENT || state_reg == ST_CLAIM))
        else $error("entry write outside update states");

    a_ring_we_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_we |-> (ent_we && kind_reg == KIND_WAIT))
        else $error("waiter write without a blocking wait");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ent_we && state_reg == ST_ENT) |-> (wr_ent.fill <= FILL_BITS'(WAIT_DEPTH)))
        else $error("ring fill beyond depth");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start");

    a_woke_signal: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.woke) |-> (kind_reg == KIND_SIGNAL))
        else $error("wake reported for a non-signal item");

endmodule

`default_nettype wire

// ----- rtl/core/named_counting_semaphore_table.sv -----
// Named counting semaphore table, top level: stream ports and result register.
// Create reads the entry memory one entry per cycle over the table, stopping at
// a name match, else claims a free entry with a write if one is free; set and
// wait read and update the entry; a signal that wakes a task adds a waiter memory read.
// One item in flight: the next item is accepted in the cycle after the result
// moves to the output register. Reset clears per-entry valid bits at once; no
// clearing pass is needed. Uses ncs_pkg and ncs_seq.
`timescale 1ns / 1ps
`default_nettype none

module named_counting_semaphore_table import ncs_pkg::*; #(
    parameter int SEM_COUNT    = SEM_COUNT_DEF,
    parameter int WAIT_DEPTH   = WAIT_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sem_id[4:0], set_value[20:5], task_id[26:21], name_low[90:27],
    // name_mid[154:91], name_high[186:155], zero[191:187]
    input  logic [191:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], result_id[6:2], caller_blocks[7], woke[8],
    // woken_task[14:9], zero[15]
    output logic [15:0]  m_tdata
);

    item_t in_item;
    res_t  res, m_res_reg;
    logic  res_valid, res_ready, m_valid_reg;

    always_comb begin
        in_item.kind      = kind_t'(s_tuser);
        in_item.sem_id    = s_tdata[4:0];
        in_item.set_value = s_tdata[20:5];
        in_item.task_id   = s_tdata[26:21];
        in_item.name      = {s_tdata[186:155], s_tdata[154:91], s_tdata[90:27]};
    end

    ncs_seq #(
        .SEM_COUNT    (SEM_COUNT),
        .WAIT_DEPTH   (WAIT_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.woken_task, m_res_reg.woke,
                       m_res_reg.caller_blocks, m_res_reg.result_id, m_res_reg.status};

endmodule

`default_nettype wire
